// ===== rtl/sgdm_pkg.sv =====
// Shared constants, types and rounding and widening helpers for the SGD momentum update core.
package sgdm_pkg;

    localparam int DATA_W     = 32;
    localparam int COEF_W     = 18;
    localparam int DAMP_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 52;
    localparam int NUM_STAGES = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [COEF_W-1:0] DEFAULT_LR = COEF_W'(66);
    localparam logic [DAMP_W-1:0] ONE_Q16    = DAMP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_DECAY_RATE    = 3'd1,
        REG_MOMENTUM      = 3'd2,
        REG_DAMPENING     = 3'd3,
        REG_NESTEROV      = 3'd4,
        REG_MAXIMIZE      = 3'd5
    } cfg_reg_e;

    // Sanitised coefficients as seen by the datapath
    typedef struct packed {
        logic [COEF_W-1:0] lr;
        logic [COEF_W-1:0] decay;
        logic [COEF_W-1:0] mom;
        logic [DAMP_W-1:0] one_minus_damp;
        logic              mom_nz;
        logic              nesterov;
        logic              maximize;
    } sgdm_cfg_t;

    // Q20.32 sum -> Q16.16, round half up, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] q_finish(input logic signed [ACC_W-1:0] sum);
        logic signed [ACC_W-1:0]        r;
        logic        [ACC_W-FRAC_W-1:0] q;
        logic                           ovf;
        r   = sum + ACC_W'(32768);
        q   = r[ACC_W-1:FRAC_W];
        ovf = !(&q[ACC_W-FRAC_W-1:DATA_W-1]) && (|q[ACC_W-FRAC_W-1:DATA_W-1]);
        if (ovf) begin
            q_finish = q[ACC_W-FRAC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            q_finish = q[DATA_W-1:0];
        end
    endfunction

    // Q16.16 value placed in the Q20.32 accumulator format
    function automatic logic signed [ACC_W-1:0] q_widen(input logic signed [DATA_W-1:0] x);
        q_widen = {{(ACC_W-DATA_W-FRAC_W){x[DATA_W-1]}}, x, {FRAC_W{1'b0}}};
    endfunction

endpackage

// ===== rtl/sgdm_cfg_regs.sv =====
// Configuration registers and coefficient sanitising for the SGD momentum update core.
module sgdm_cfg_regs
    import sgdm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output sgdm_cfg_t             cfg
);

    logic [COEF_W-1:0] lr_reg;
    logic [COEF_W-1:0] decay_reg;
    logic [COEF_W-1:0] mom_reg;
    logic [DAMP_W-1:0] damp_reg;
    logic              nesterov_reg;
    logic              maximize_reg;
    logic [DAMP_W-1:0] damp_clamped;
    logic [DAMP_W-1:0] damp_used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg       <= DEFAULT_LR;
            decay_reg    <= '0;
            mom_reg      <= '0;
            damp_reg     <= '0;
            nesterov_reg <= 1'b0;
            maximize_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LEARNING_RATE: lr_reg       <= cfg_data;
                REG_DECAY_RATE:    decay_reg    <= cfg_data;
                REG_MOMENTUM:      mom_reg      <= cfg_data;
                REG_DAMPENING:     damp_reg     <= cfg_data[DAMP_W-1:0];
                REG_NESTEROV:      nesterov_reg <= cfg_data[0];
                REG_MAXIMIZE:      maximize_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        damp_clamped = (damp_reg > ONE_Q16) ? ONE_Q16 : damp_reg;
        // Nesterov ignores dampening
        damp_used    = nesterov_reg ? '0 : damp_clamped;

        cfg.lr             = (lr_reg == '0) ? DEFAULT_LR : lr_reg;
        cfg.decay          = decay_reg;
        cfg.mom            = mom_reg;
        cfg.one_minus_damp = ONE_Q16 - damp_used;
        cfg.mom_nz         = (mom_reg != '0);
        cfg.nesterov       = nesterov_reg && (mom_reg != '0);
        cfg.maximize       = maximize_reg;
    end

endmodule

// ===== rtl/sgdm_flow.sv =====
// Stage valid bits and per-stage load enables for the update pipeline.
module sgdm_flow
    import sgdm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [NUM_STAGES-1:0] stage_load
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        stage_load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_load[i] = !valid_reg[i] || stage_load[i+1];
        end
        valid_next = valid_reg;
        if (stage_load[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_load[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

endmodule

// ===== rtl/sgdm_datapath.sv =====
// Eight-stage arithmetic datapath: decay, velocity, Nesterov look-ahead and weight step.
module sgdm_datapath
    import sgdm_pkg::*;
(
    input  logic                     aclk,
    input  sgdm_cfg_t                cfg,
    input  logic [NUM_STAGES-1:0]    stage_load,
    input  logic signed [DATA_W-1:0] weight_in,
    input  logic signed [DATA_W-1:0] gradient_in,
    input  logic signed [DATA_W-1:0] velocity_in,
    output logic signed [DATA_W-1:0] weight_out,
    output logic signed [DATA_W-1:0] velocity_out
);

    // stage 1: weight decay and momentum*velocity products
    logic signed [DATA_W-1:0] w1_reg, grad1_reg, vel1_reg;
    logic signed [ACC_W-1:0]  pdec1_reg, pmv1_reg, pdec1_next, pmv1_next;
    // stage 2: decayed gradient
    logic signed [DATA_W-1:0] w2_reg, vel2_reg, g2_reg, g2_next;
    logic signed [ACC_W-1:0]  pmv2_reg;
    // stage 3: (1 - dampening) * g
    logic signed [DATA_W-1:0] w3_reg, vel3_reg, g3_reg;
    logic signed [ACC_W-1:0]  pmv3_reg, pdg3_reg, pdg3_next;
    // stage 4: new velocity
    logic signed [DATA_W-1:0] w4_reg, g4_reg, vnew4_reg, vnew4_next;
    // stage 5: momentum * new velocity
    logic signed [DATA_W-1:0] w5_reg, g5_reg, vnew5_reg;
    logic signed [ACC_W-1:0]  pmvn5_reg, pmvn5_next;
    // stage 6: update direction
    logic signed [DATA_W-1:0] w6_reg, vnew6_reg, upd6_reg, upd6_next;
    // stage 7: lr * update
    logic signed [DATA_W-1:0] w7_reg, vnew7_reg;
    logic signed [ACC_W-1:0]  plr7_reg, plr7_next;
    // stage 8: weight step into the output register
    logic signed [DATA_W-1:0] wout8_reg, vout8_reg, wout8_next;

    always_comb begin
        pdec1_next = ACC_W'($signed({1'b0, cfg.decay})) * ACC_W'(weight_in);
        pmv1_next  = ACC_W'($signed({1'b0, cfg.mom})) * ACC_W'(velocity_in);
        g2_next    = q_finish(q_widen(grad1_reg) + pdec1_reg);
        pdg3_next  = ACC_W'($signed({1'b0, cfg.one_minus_damp})) * ACC_W'(g2_reg);
        vnew4_next = cfg.mom_nz ? q_finish(pmv3_reg + pdg3_reg) : vel3_reg;
        pmvn5_next = ACC_W'($signed({1'b0, cfg.mom})) * ACC_W'(vnew4_reg);
        if (cfg.nesterov) begin
            upd6_next = q_finish(q_widen(g5_reg) + pmvn5_reg);
        end else if (cfg.mom_nz) begin
            upd6_next = vnew5_reg;
        end else begin
            upd6_next = g5_reg;
        end
        plr7_next  = ACC_W'($signed({1'b0, cfg.lr})) * ACC_W'(upd6_reg);
        wout8_next = cfg.maximize ? q_finish(q_widen(w7_reg) + plr7_reg)
                                  : q_finish(q_widen(w7_reg) - plr7_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            w1_reg    <= weight_in;
            grad1_reg <= gradient_in;
            vel1_reg  <= velocity_in;
            pdec1_reg <= pdec1_next;
            pmv1_reg  <= pmv1_next;
        end
        if (stage_load[1]) begin
            w2_reg   <= w1_reg;
            vel2_reg <= vel1_reg;
            pmv2_reg <= pmv1_reg;
            g2_reg   <= g2_next;
        end
        if (stage_load[2]) begin
            w3_reg   <= w2_reg;
            vel3_reg <= vel2_reg;
            g3_reg   <= g2_reg;
            pmv3_reg <= pmv2_reg;
            pdg3_reg <= pdg3_next;
        end
        if (stage_load[3]) begin
            w4_reg    <= w3_reg;
            g4_reg    <= g3_reg;
            vnew4_reg <= vnew4_next;
        end
        if (stage_load[4]) begin
            w5_reg    <= w4_reg;
            g5_reg    <= g4_reg;
            vnew5_reg <= vnew4_reg;
            pmvn5_reg <= pmvn5_next;
        end
        if (stage_load[5]) begin
            w6_reg    <= w5_reg;
            vnew6_reg <= vnew5_reg;
            upd6_reg  <= upd6_next;
        end
        if (stage_load[6]) begin
            w7_reg    <= w6_reg;
            vnew7_reg <= vnew6_reg;
            plr7_reg  <= plr7_next;
        end
        if (stage_load[7]) begin
            wout8_reg <= wout8_next;
            vout8_reg <= vnew7_reg;
        end
    end

    assign weight_out   = wout8_reg;
    assign velocity_out = vout8_reg;

endmodule

// ===== rtl/sgd_momentum_update_core.sv =====
// Top level of the SGD momentum update core: config port, flow control and datapath.
//
// Per-element SGD step with weight decay, classic or Nesterov momentum with dampening
// and a maximize option, on signed Q16.16 data with unsigned Q2.16 coefficients; every
// sum is rounded half up and saturated to 32 bits. The pipeline has eight register
// stages, each holding at most one multiply level or one accumulate-round-saturate,
// so one transaction is accepted per cycle while m_ready is high, and the last stage is
// the output register; back-pressure stalls only the stages that are full.
// Configuration writes are always accepted and must only be issued while the pipeline
// is empty; a learning rate of zero is taken as 66, dampening is clamped to 1.0.
module sgd_momentum_update_core
    import sgdm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_weight_in,
    input  logic signed [DATA_W-1:0] s_gradient_in,
    input  logic signed [DATA_W-1:0] s_velocity_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_weight_out,
    output logic signed [DATA_W-1:0] m_velocity_out
);

    sgdm_cfg_t             cfg;
    logic [NUM_STAGES-1:0] stage_load;

    sgdm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sgdm_flow u_flow (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stage_load (stage_load)
    );

    sgdm_datapath u_dp (
        .aclk         (aclk),
        .cfg          (cfg),
        .stage_load   (stage_load),
        .weight_in    (s_weight_in),
        .gradient_in  (s_gradient_in),
        .velocity_in  (s_velocity_in),
        .weight_out   (m_weight_out),
        .velocity_out (m_velocity_out)
    );

    // An empty or draining output stage means nothing upstream can be blocked
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output stage free");

    // With no back-pressure a transaction reaches the output after eight stages
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
            ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("transaction lost in pipeline");

    // A stalled result holds still until it is taken
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_weight_out)
                                   && $stable(m_velocity_out)))
        else $error("result changed while stalled");

endmodule

// ===== tb/tb_sgd_momentum_update_core.sv =====
// Self-checking testbench for the SGD momentum update core.
module tb_sgd_momentum_update_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sgdm_pkg::*;

    localparam int CLK_HALF = 6;
    // indexes past the register list, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam int NUM_SETTINGS = 12;
    localparam int ITEMS_PER_SETTING = 125;

    typedef struct packed {
        logic [DATA_W-1:0] weight;
        logic [DATA_W-1:0] velocity;
    } step_result_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [DATA_W-1:0]     w;
        logic [DATA_W-1:0]     g;
        logic [DATA_W-1:0]     v;
        step_result_t          want;
    } row_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_weight_in   = '0;
    logic [DATA_W-1:0]     s_gradient_in = '0;
    logic [DATA_W-1:0]     s_velocity_in = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [DATA_W-1:0]     m_weight_out;
    logic [DATA_W-1:0]     m_velocity_out;

    // shadow of the block's registers
    logic [COEF_W-1:0] lr_q    = DEFAULT_LR;
    logic [COEF_W-1:0] decay_q = '0;
    logic [COEF_W-1:0] mom_q   = '0;
    logic [DAMP_W-1:0] damp_q  = '0;
    logic              nest_q  = 1'b0;
    logic              max_q   = 1'b0;

    step_result_t      expected_updates[$];
    step_result_t      last_update   = '0;
    row_t              directed [0:31];
    int                err_count     = 0;
    int                tx_idle_pct   = 10;
    int                rx_idle_pct   = 52;
    int                rx_hold_req   = 0;
    int                rx_hold_left  = 0;

    sgd_momentum_update_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_weight_in    (s_weight_in),
        .s_gradient_in  (s_gradient_in),
        .s_velocity_in  (s_velocity_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_weight_out   (m_weight_out),
        .m_velocity_out (m_velocity_out)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Q32.32 -> Q16.16, round half up, clamp to 32 bits
    function automatic logic signed [DATA_W-1:0] round_sat(input longint acc);
        longint q;
        q = (acc + 64'sd32768) >>> FRAC_W;
        if (q > 64'sd2147483647) return Q_MAX;
        if (q < -64'sd2147483648) return Q_MIN;
        return q[DATA_W-1:0];
    endfunction

    function automatic step_result_t sgd_step(input logic signed [DATA_W-1:0] w,
                                              input logic signed [DATA_W-1:0] grad,
                                              input logic signed [DATA_W-1:0] vel);
        longint       lr;
        longint       mom;
        longint       damp;
        longint       g;
        longint       v_new;
        longint       upd;
        longint       w_acc;
        step_result_t r;
        lr    = (lr_q == '0) ? longint'(DEFAULT_LR) : longint'(lr_q);
        mom   = longint'(mom_q);
        damp  = (damp_q > ONE_Q16) ? longint'(ONE_Q16) : longint'(damp_q);
        g     = longint'(round_sat(longint'(grad) * 65536
                                   + longint'(decay_q) * longint'(w)));
        if (mom != 0) begin
            if (nest_q) damp = 0;
            v_new = longint'(round_sat(mom * longint'(vel) + (65536 - damp) * g));
            if (nest_q) begin
                upd = longint'(round_sat(g * 65536 + mom * v_new));
            end else begin
                upd = v_new;
            end
        end else begin
            v_new = longint'(vel);
            upd   = g;
        end
        w_acc = longint'(w) * 65536;
        if (max_q) begin
            w_acc = w_acc + lr * upd;
        end else begin
            w_acc = w_acc - lr * upd;
        end
        r.weight   = round_sat(w_acc);
        r.velocity = v_new[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_q16();
        case ($urandom_range(9))
            0, 1: begin
                case ($urandom_range(4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return Q_ONE;
                endcase
            end
            2, 3, 4, 5: return DATA_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            default:    return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef(input int setting);
        if (setting == 0) return '0;
        if (setting == 1) return '1;
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(0, 65536));
            3:       return CFG_DATA_W'($urandom_range(0, 4096));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_damp(input int setting);
        if (setting == 0) return '0;
        if (setting == 1) return 18'h1FFFF;
        case ($urandom_range(3))
            0:       return '0;
            1:       return CFG_DATA_W'(ONE_Q16);
            2:       return CFG_DATA_W'($urandom_range(0, 65536));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_flag(input int setting);
        if (setting == 0) return '0;
        if (setting == 1) return '1;
        return CFG_DATA_W'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
        err_count++;
    endtask

    // drop valid, let every outstanding result drain, then let the pipe go quiet
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_updates.size() != 0) @(posedge aclk);
        repeat (NUM_STAGES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEARNING_RATE: lr_q    = val[COEF_W-1:0];
            REG_DECAY_RATE:    decay_q = val[COEF_W-1:0];
            REG_MOMENTUM:      mom_q   = val[COEF_W-1:0];
            REG_DAMPENING:     damp_q  = val[DAMP_W-1:0];
            REG_NESTEROV:      nest_q  = val[0];
            REG_MAXIMIZE:      max_q   = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_item(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] g,
                             input logic [DATA_W-1:0] v, input bit use_fixed,
                             input step_result_t fixed);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            if (s_valid) s_valid <= 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_weight_in   <= w;
        s_gradient_in <= g;
        s_velocity_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_update = use_fixed ? fixed : sgd_step(w, g, v);
        expected_updates.push_back(last_update);
    endtask

    // receiver: random stalls plus a long hold-off when one is requested
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        step_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_updates.size() == 0) begin
                report_mismatch("unexpected result, weight", m_weight_out, 'x);
            end else begin
                want = expected_updates.pop_front();
                if (m_weight_out !== want.weight)
                    report_mismatch("weight_out", m_weight_out, want.weight);
                if (m_velocity_out !== want.velocity)
                    report_mismatch("velocity_out", m_velocity_out, want.velocity);
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] w_next;
        logic [DATA_W-1:0] v_next;
        directed = '{
            '{ROW_CHECKED, '0, '0, 32'h0, 32'h0, 32'h0, '{32'h0, 32'h0}},
            '{ROW_CHECKED, '0, '0, Q_MAX, Q_MIN, Q_MAX, '{Q_MAX, Q_MAX}},
            '{ROW_CHECKED, '0, '0, Q_MIN, Q_MAX, Q_MIN, '{Q_MIN, Q_MIN}},
            '{ROW_CHECKED, '0, '0, Q_ONE, Q_ONE, 32'h12345678, '{32'h0000FFBE, 32'h12345678}},
            // zero learning rate falls back to the default
            '{ROW_CFG, REG_LEARNING_RATE, 18'h0, '0, '0, '0, '0},
            '{ROW_CHECKED, '0, '0, Q_ONE, Q_ONE, 32'hFFFF0000, '{32'h0000FFBE, 32'hFFFF0000}},
            // Nesterov without momentum is plain SGD
            '{ROW_CFG, REG_NESTEROV, 18'h1, '0, '0, '0, '0},
            '{ROW_CHECKED, '0, '0, Q_ONE, Q_ONE, 32'h00ABCDEF, '{32'h0000FFBE, 32'h00ABCDEF}},
            '{ROW_CFG, REG_SPARE_A, 18'h3FFFF, '0, '0, '0, '0},
            '{ROW_CFG, REG_SPARE_B, 18'h12345, '0, '0, '0, '0},
            '{ROW_CHECKED, '0, '0, Q_ONE, Q_ONE, 32'hFFFFFFFF, '{32'h0000FFBE, 32'hFFFFFFFF}},
            // Nesterov with dampening set: dampening must be ignored
            '{ROW_CFG, REG_MOMENTUM, 18'h0E666, '0, '0, '0, '0},
            '{ROW_CFG, REG_DAMPENING, 18'h08000, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, Q_ONE, 32'h00020000, 32'h00008000, '0},
            '{ROW_ITEM, '0, '0, Q_MAX, Q_MAX, Q_MAX, '0},
            // only bit 0 of the flag is kept
            '{ROW_CFG, REG_NESTEROV, 18'h2, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, 32'hFFF00000, 32'h00048000, 32'hFFFF8000, '0},
            // dampening above 1.0 clamps
            '{ROW_CFG, REG_DAMPENING, 18'h1FFFF, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, Q_ONE, 32'h00030000, 32'h00010000, '0},
            // bit 17 is outside the dampening register
            '{ROW_CFG, REG_DAMPENING, 18'h20000, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, 32'h0, 32'hFFFF0000, Q_MIN, '0},
            '{ROW_CFG, REG_DECAY_RATE, 18'h3FFFF, '0, '0, '0, '0},
            '{ROW_CFG, REG_LEARNING_RATE, 18'h3FFFF, '0, '0, '0, '0},
            '{ROW_CFG, REG_MAXIMIZE, 18'h1, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, Q_MIN, Q_MIN, Q_MIN, '0},
            '{ROW_ITEM, '0, '0, Q_MAX, Q_MAX, Q_MIN, '0},
            '{ROW_CFG, REG_MOMENTUM, 18'h3FFFF, '0, '0, '0, '0},
            '{ROW_CFG, REG_NESTEROV, 18'h1, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, Q_MIN, Q_MAX, Q_MAX, '0},
            '{ROW_ITEM, '0, '0, 32'h00054321, 32'hFFFABCDE, 32'h0001F000, '0},
            '{ROW_CFG, REG_MAXIMIZE, 18'h0, '0, '0, '0, '0},
            '{ROW_ITEM, '0, '0, 32'h00054321, 32'hFFFABCDE, 32'h0001F000, '0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            case (directed[i].kind)
                ROW_CFG: begin
                    settle_idle();
                    write_reg(directed[i].idx, directed[i].data);
                end
                ROW_ITEM:
                    send_item(directed[i].w, directed[i].g, directed[i].v, 1'b0, '0);
                default:
                    send_item(directed[i].w, directed[i].g, directed[i].v, 1'b1,
                              directed[i].want);
            endcase
        end

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            settle_idle();
            if (s < NUM_SETTINGS / 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 52;
            end else if (s < 2 * NUM_SETTINGS / 3) begin
                tx_idle_pct = 52;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(REG_LEARNING_RATE, pick_coef(s));
            write_reg(REG_DECAY_RATE, (s > 1 && $urandom_range(1)) ? 18'h0 : pick_coef(s));
            write_reg(REG_MOMENTUM, pick_coef(s));
            write_reg(REG_DAMPENING, pick_damp(s));
            write_reg(REG_NESTEROV, pick_flag(s));
            write_reg(REG_MAXIMIZE, pick_flag(s));
            if (s > 1) write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));

            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                // long receiver hold-off while the sender keeps going
                if (s == NUM_SETTINGS - 3 && k == 40) rx_hold_req = 120;
                // sender waits for the pipe to empty mid-setting
                if (s == NUM_SETTINGS - 3 && k == 90) settle_idle();
                // feed back the previous weight half the time and velocity mostly
                w_next = $urandom_range(1) ? last_update.weight : rand_q16();
                v_next = $urandom_range(3) != 0 ? last_update.velocity : rand_q16();
                send_item(w_next, rand_q16(), v_next, 1'b0, '0);
            end
        end

        settle_idle();
        repeat (4 * NUM_STAGES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_updates.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sgdm_pkg.sv
rtl/sgdm_cfg_regs.sv
rtl/sgdm_flow.sv
rtl/sgdm_datapath.sv
rtl/sgd_momentum_update_core.sv
tb/tb_sgd_momentum_update_core.sv
